[design/toom4nc_pkg.sv]
`default_nettype none

package toom4nc_pkg;

    // register stages from input transaction to output register
    localparam int NSTG = 12;

    localparam int AW = 39;     // A coefficients, evaluations, products
    localparam int BW = 29;     // B coefficients and evaluations
    localparam int PW = 36;     // result coefficients

    localparam logic [35:0] INV3  = 36'hAAAAAAAAB;
    localparam logic [36:0] INV15 = 37'h0EEEEEEEEF;
    localparam logic [36:0] INV9  = 37'h0E38E38E39;

    typedef logic [3:0][AW-1:0] coef_t;
    typedef logic [6:0][AW-1:0] ev_t;
    typedef logic [6:0][BW-1:0] evb_t;

    // partial products of a truncated multiply, low half by full, high by low
    typedef struct packed {
        logic [35:0] p00;
        logic [17:0] p01;
        logic [17:0] p10;
    } pp36_t;

    typedef struct packed {
        logic [36:0] p00;
        logic [17:0] p01;
        logic [17:0] p10;
    } pp37_t;

    // evaluation at inf, 2, 1, -1, 1/2 (x8), -1/2 (x8), 0, modulo 2^39
    function automatic ev_t eval7(input coef_t r);
        ev_t           e;
        logic [AW-1:0] s;
        logic [AW-1:0] d;
        e[0] = r[3];
        e[1] = (r[3] << 3) + (r[2] << 2) + (r[1] << 1) + r[0];
        s    = r[0] + r[2];
        d    = r[1] + r[3];
        e[2] = s + d;
        e[3] = s - d;
        s    = ((r[0] << 2) + r[2]) << 1;
        d    = (r[1] << 2) + r[3];
        e[4] = s + d;
        e[5] = s - d;
        e[6] = r[0];
        return e;
    endfunction

    function automatic pp36_t part36(input logic [35:0] t, input logic [35:0] c);
        pp36_t       pp;
        logic [35:0] f00;
        logic [35:0] f01;
        logic [35:0] f10;
        f00    = t[17:0] * c[17:0];
        f01    = t[17:0] * c[35:18];
        f10    = t[35:18] * c[17:0];
        pp.p00 = f00;
        pp.p01 = f01[17:0];
        pp.p10 = f10[17:0];
        return pp;
    endfunction

    function automatic pp37_t part37(input logic [36:0] t, input logic [36:0] c);
        pp37_t       pp;
        logic [37:0] f00;
        logic [36:0] f01;
        logic [36:0] f10;
        f00    = t[18:0] * c[18:0];
        f01    = t[18:0] * c[36:19];
        f10    = t[36:19] * c[18:0];
        pp.p00 = f00[36:0];
        pp.p01 = f01[17:0];
        pp.p10 = f10[17:0];
        return pp;
    endfunction

    function automatic logic [35:0] fold36(input pp36_t pp);
        logic [17:0] hi;
        hi = pp.p01 + pp.p10;
        return pp.p00 + {hi, 18'd0};
    endfunction

    function automatic logic [36:0] fold37(input pp37_t pp);
        logic [17:0] hi;
        hi = pp.p01 + pp.p10;
        return pp.p00 + {hi, 19'd0};
    endfunction

endpackage

`default_nettype wire

[design/toom4_negacyclic_poly_multiply.sv]
// Toom-Cook 4-way product of two 4-term polynomials modulo x^4+1.
// The pipeline has 12 register stages; the last one is the output register
// that drives the result ports.
// Throughput: one transaction per cycle; each stage holds only when the stages
// after it are full, so bubbles are squeezed out under backpressure.
// Reset clears the stage valid bits only; the datapath registers are not reset.
`default_nettype none

module toom4_negacyclic_poly_multiply
    import toom4nc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire logic [AW-1:0]     a_coef0,
    input  wire logic [AW-1:0]     a_coef1,
    input  wire logic [AW-1:0]     a_coef2,
    input  wire logic [AW-1:0]     a_coef3,
    input  wire logic [BW-1:0]     b_coef0,
    input  wire logic [BW-1:0]     b_coef1,
    input  wire logic [BW-1:0]     b_coef2,
    input  wire logic [BW-1:0]     b_coef3,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      logic [PW-1:0]     prod_coef0,
    output      logic [PW-1:0]     prod_coef1,
    output      logic [PW-1:0]     prod_coef2,
    output      logic [PW-1:0]     prod_coef3
);

    // ---------------------------------------------------------------
    // Stage control
    // ---------------------------------------------------------------
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic [NSTG-1:0] en;

    // a stage may load unless it and every stage after it are full and out_ready is low
    for (genvar g = 0; g < NSTG; g++) begin : g_en
        assign en[g] = out_ready || !(&valid_reg[NSTG-1:g]);
    end

    assign valid_next = {valid_reg[NSTG-2:0], in_valid};
    assign in_ready   = en[0];
    assign out_valid  = valid_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // S1: evaluation
    // ---------------------------------------------------------------
    coef_t ca;
    coef_t cb;
    ev_t   s1_ea_next;
    ev_t   eb_full;
    evb_t  s1_eb_next;
    ev_t   s1_ea_reg;
    evb_t  s1_eb_reg;

    always_comb
    begin
        ca = {a_coef3, a_coef2, a_coef1, a_coef0};
        cb = {{(AW-BW){1'b0}}, b_coef3, {(AW-BW){1'b0}}, b_coef2,
              {(AW-BW){1'b0}}, b_coef1, {(AW-BW){1'b0}}, b_coef0};
        s1_ea_next = eval7(ca);
        eb_full    = eval7(cb);
        for (int k = 0; k < 7; k++)
        begin
            s1_eb_next[k] = eb_full[k][BW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_ea_reg <= s1_ea_next;
            s1_eb_reg <= s1_eb_next;
        end
    end

    // ---------------------------------------------------------------
    // S2: pointwise products, A split at bit 20, B signed
    // ---------------------------------------------------------------
    logic signed [49:0]        pl_full [7];
    logic signed [48:0]        ph_full [7];
    logic [6:0][AW-1:0]        s2_pl_next;
    logic [6:0][18:0]          s2_ph_next;
    logic [6:0][AW-1:0]        s2_pl_reg;
    logic [6:0][18:0]          s2_ph_reg;

    always_comb
    begin
        for (int k = 0; k < 7; k++)
        begin
            pl_full[k]    = $signed({1'b0, s1_ea_reg[k][19:0]}) * $signed(s1_eb_reg[k]);
            ph_full[k]    = $signed({1'b0, s1_ea_reg[k][38:20]}) * $signed(s1_eb_reg[k]);
            s2_pl_next[k] = pl_full[k][AW-1:0];
            s2_ph_next[k] = ph_full[k][18:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_pl_reg <= s2_pl_next;
            s2_ph_reg <= s2_ph_next;
        end
    end

    // ---------------------------------------------------------------
    // S3: products modulo 2^39
    // ---------------------------------------------------------------
    ev_t s3_w_next;
    ev_t s3_w_reg;

    always_comb
    begin
        for (int k = 0; k < 7; k++)
        begin
            s3_w_next[k] = s2_pl_reg[k] + {s2_ph_reg[k], 20'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_w_reg <= s3_w_next;
        end
    end

    // ---------------------------------------------------------------
    // S4..S8: interpolation, modulo 2^39
    // ---------------------------------------------------------------
    logic [AW-1:0] d32;
    logic [AW-1:0] s4_v5_next, s4_v4_next;
    logic [AW-2:0] s4_v3_next;
    logic [AW-1:0] s4_w0_reg, s4_w1_reg, s4_w2_reg, s4_w4_reg, s4_w6_reg;
    logic [AW-1:0] s4_v5_reg, s4_v4_reg;
    logic [AW-2:0] s4_v3_reg;

    always_comb
    begin
        s4_v5_next = s3_w_reg[5] - s3_w_reg[4];
        d32        = s3_w_reg[3] - s3_w_reg[2];
        s4_v3_next = d32[AW-1:1];
        s4_v4_next = s3_w_reg[4] - s3_w_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_w0_reg <= s3_w_reg[0];
            s4_w1_reg <= s3_w_reg[1];
            s4_w2_reg <= s3_w_reg[2];
            s4_w4_reg <= s3_w_reg[4];
            s4_w6_reg <= s3_w_reg[6];
            s4_v5_reg <= s4_v5_next;
            s4_v4_reg <= s4_v4_next;
            s4_v3_reg <= s4_v3_next;
        end
    end

    logic [AW-1:0] s5_v4_next, s5_v2_next;
    logic [AW-1:0] s5_w0_reg, s5_w1_reg, s5_w4_reg, s5_w6_reg;
    logic [AW-1:0] s5_v5_reg, s5_v4_reg, s5_v2_reg;
    logic [AW-2:0] s5_v3_reg;

    always_comb
    begin
        s5_v4_next = (s4_v4_reg << 1) + s4_v5_reg - (s4_w6_reg << 7);
        s5_v2_next = s4_w2_reg + {1'b0, s4_v3_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_w0_reg <= s4_w0_reg;
            s5_w1_reg <= s4_w1_reg;
            s5_w4_reg <= s4_w4_reg;
            s5_w6_reg <= s4_w6_reg;
            s5_v5_reg <= s4_v5_reg;
            s5_v3_reg <= s4_v3_reg;
            s5_v4_reg <= s5_v4_next;
            s5_v2_reg <= s5_v2_next;
        end
    end

    logic [AW-1:0] s6_v1_next, s6_v2_next;
    logic [AW-1:0] s6_w0_reg, s6_w6_reg, s6_v5_reg, s6_v4_reg, s6_v1_reg, s6_v2_reg;
    logic [AW-2:0] s6_v3_reg;

    always_comb
    begin
        s6_v1_next = s5_w1_reg + s5_w4_reg - (s5_v2_reg << 6) - s5_v2_reg;
        s6_v2_next = s5_v2_reg - s5_w6_reg - s5_w0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s6_w0_reg <= s5_w0_reg;
            s6_w6_reg <= s5_w6_reg;
            s6_v5_reg <= s5_v5_reg;
            s6_v3_reg <= s5_v3_reg;
            s6_v4_reg <= s5_v4_reg;
            s6_v1_reg <= s6_v1_next;
            s6_v2_reg <= s6_v2_next;
        end
    end

    logic [AW-1:0] s7_v1_next;
    logic [AW-1:0] t4_full;
    logic [35:0]   s7_t4_next;
    logic [AW-1:0] s7_w0_reg, s7_w6_reg, s7_v5_reg, s7_v1_reg, s7_v2_reg;
    logic [AW-2:0] s7_v3_reg;
    logic [35:0]   s7_t4_reg;

    always_comb
    begin
        // v1 + 45 * v2
        s7_v1_next = s6_v1_reg + s6_v2_reg + (s6_v2_reg << 2) + (s6_v2_reg << 3)
                     + (s6_v2_reg << 5);
        t4_full    = s6_v4_reg - (s6_v2_reg << 3);
        s7_t4_next = t4_full[AW-1:3];
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s7_w0_reg <= s6_w0_reg;
            s7_w6_reg <= s6_w6_reg;
            s7_v5_reg <= s6_v5_reg;
            s7_v3_reg <= s6_v3_reg;
            s7_v2_reg <= s6_v2_reg;
            s7_v1_reg <= s7_v1_next;
            s7_t4_reg <= s7_t4_next;
        end
    end

    // only bits [37:1] of each halved sum survive the 37-bit multiply
    logic [AW-1:0] sum5, sum1;
    logic [36:0]   s8_s5_next, s8_s1_next;
    logic [AW-1:0] s8_w0_reg, s8_w6_reg, s8_v2_reg;
    logic [AW-2:0] s8_v3_reg;
    logic [35:0]   s8_t4_reg;
    logic [36:0]   s8_s5_reg, s8_s1_reg;

    always_comb
    begin
        sum5       = s7_v5_reg + s7_v1_reg;
        sum1       = s7_v1_reg + {s7_v3_reg[34:0], 4'd0};
        s8_s5_next = sum5[37:1];
        s8_s1_next = sum1[37:1];
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s8_w0_reg <= s7_w0_reg;
            s8_w6_reg <= s7_w6_reg;
            s8_v3_reg <= s7_v3_reg;
            s8_v2_reg <= s7_v2_reg;
            s8_t4_reg <= s7_t4_reg;
            s8_s5_reg <= s8_s5_next;
            s8_s1_reg <= s8_s1_next;
        end
    end

    // ---------------------------------------------------------------
    // S9, S10: exact division by 3, 15 and 9 via inverse multipliers
    // ---------------------------------------------------------------
    pp36_t         s9_m4_reg;
    pp37_t         s9_m5_reg, s9_m1_reg;
    logic [AW-1:0] s9_w0_reg, s9_w6_reg, s9_v2_reg;
    logic [AW-2:0] s9_v3_reg;

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s9_m4_reg <= part36(s8_t4_reg, INV3);
            s9_m5_reg <= part37(s8_s5_reg, INV15);
            s9_m1_reg <= part37(s8_s1_reg, INV9);
            s9_w0_reg <= s8_w0_reg;
            s9_w6_reg <= s8_w6_reg;
            s9_v3_reg <= s8_v3_reg;
            s9_v2_reg <= s8_v2_reg;
        end
    end

    logic [35:0]   s10_v4_reg;
    logic [36:0]   s10_v5_reg, s10_v1_reg;
    logic [AW-1:0] s10_w0_reg, s10_w6_reg, s10_v2_reg;
    logic [AW-2:0] s10_v3_reg;

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            s10_v4_reg <= fold36(s9_m4_reg);
            s10_v5_reg <= fold37(s9_m5_reg);
            s10_v1_reg <= fold37(s9_m1_reg);
            s10_w0_reg <= s9_w0_reg;
            s10_w6_reg <= s9_w6_reg;
            s10_v3_reg <= s9_v3_reg;
            s10_v2_reg <= s9_v2_reg;
        end
    end

    // ---------------------------------------------------------------
    // S11: final corrections, S12: output register
    // ---------------------------------------------------------------
    logic [PW-1:0] s11_v2_next, s11_v3_next;
    logic [36:0]   d15;
    logic [PW-1:0] s11_v5_next;
    logic [PW-1:0] s11_v2_reg, s11_v3_reg, s11_v5_reg, s11_v4_reg;
    logic [36:0]   s11_v1_reg;
    logic [PW-1:0] s11_w0_reg, s11_w6_reg;

    always_comb
    begin
        s11_v2_next = s10_v2_reg[PW-1:0] - s10_v4_reg;
        s11_v3_next = {PW{1'b0}} - s10_v3_reg[PW-1:0] - s10_v1_reg[PW-1:0];
        d15         = s10_v1_reg - s10_v5_reg;
        s11_v5_next = d15[36:1];
    end

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            s11_v2_reg <= s11_v2_next;
            s11_v3_reg <= s11_v3_next;
            s11_v5_reg <= s11_v5_next;
            s11_v4_reg <= s10_v4_reg;
            s11_v1_reg <= s10_v1_reg;
            s11_w0_reg <= s10_w0_reg[PW-1:0];
            s11_w6_reg <= s10_w6_reg[PW-1:0];
        end
    end

    logic [PW-1:0] out0_reg, out1_reg, out2_reg, out3_reg;

    always_ff @(posedge clk)
    begin
        if (en[11])
        begin
            out0_reg <= s11_w6_reg - s11_v2_reg;
            // v5 - (v1 - v5)
            out1_reg <= {s11_v5_reg[PW-2:0], 1'b0} - s11_v1_reg[PW-1:0];
            out2_reg <= s11_v4_reg - s11_w0_reg;
            out3_reg <= s11_v3_reg;
        end
    end

    assign prod_coef0 = out0_reg;
    assign prod_coef1 = out1_reg;
    assign prod_coef2 = out2_reg;
    assign prod_coef3 = out3_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_no_stall_when_drained: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready
    ) else $error("input held off while output drains");

    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&valid_reg) && !out_ready
    ) else $error("input held off with a free stage");

    a_first_stage_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        valid_reg[0] && !en[1] |=> valid_reg[0]
    ) else $error("stalled transaction dropped from first stage");

endmodule

`default_nettype wire
